FILE: src/midi_note_voice_allocator_assert.svh
// ----------------------------------------------------------------------------
// midi_note_voice_allocator_assert.svh
// Assertion macros for the MIDI note voice allocator. Define NO_ASSERTIONS
// to compile them away.
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTE_VOICE_ALLOCATOR_ASSERT_SVH
`define MIDI_NOTE_VOICE_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked outside reset
`define MNVA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MNVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MNVA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define MNVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: src/mnva_pkg.sv
// ----------------------------------------------------------------------------
// mnva_pkg
// Shared types and constants of the MIDI note voice allocator.
// ----------------------------------------------------------------------------
package mnva_pkg;

    // MIDI status codes (upper nibble)
    localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
    localparam logic [3:0] CMD_NOTE_OFF = 4'h8;

    // parse modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_OFF  = 2'd2;

    // reset value of the listen channel
    localparam logic [3:0] LISTEN_CHANNEL_RST = 4'd2;

    // voice index width wide enough for the largest supported voice count
    localparam int VOICE_IDX_MAX_W = 4;

    // access to the voice table: one read/write index per cycle
    typedef struct packed {
        logic [VOICE_IDX_MAX_W-1:0] idx;
        logic                       note_we;
        logic [6:0]                 note_wdata;
        logic                       trig_we;
        logic                       trig_wdata;
    } t_tbl_cmd;

endpackage

FILE: src/mnva_voice_table.sv
// ----------------------------------------------------------------------------
// mnva_voice_table
// Per-voice note and trigger storage with one shared read/write index.
// ----------------------------------------------------------------------------
module mnva_voice_table #(
    parameter int VOICE_COUNT = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mnva_pkg::t_tbl_cmd      i_cmd,
    output logic [6:0]              o_rd_note,
    output logic [VOICE_COUNT-1:0]  o_trig
);

    localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    logic [6:0]             r_notes [VOICE_COUNT];
    logic [VOICE_COUNT-1:0] r_trig;
    logic [IDX_W-1:0]       w_idx;

    assign w_idx     = i_cmd.idx[IDX_W-1:0];
    assign o_rd_note = r_notes[w_idx];
    assign o_trig    = r_trig;

    // note store, all voices free after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < VOICE_COUNT; i++) begin
                r_notes[i] <= 7'd0;
            end
        end else if (i_cmd.note_we) begin
            r_notes[w_idx] <= i_cmd.note_wdata;
        end
    end

    // trigger bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig <= '0;
        end else if (i_cmd.trig_we) begin
            r_trig[w_idx] <= i_cmd.trig_wdata;
        end
    end

endmodule

FILE: src/midi_note_voice_allocator.sv
// ----------------------------------------------------------------------------
// midi_note_voice_allocator
// MIDI note-on/note-off parser that assigns voices by scanning the voice
// table one slot per cycle and reports each completed note message.
// ----------------------------------------------------------------------------
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+------------------------------------
//  cfg     | i_cfg_valid | o_cfg_ready | i_cfg_data (listen channel)
//  in      | i_in_valid  | o_in_ready  | i_midi_byte
//  out     | o_out_valid | i_out_ready | o_event_kind .. o_trigger_mask
//
//  Status bytes and ignored data bytes are handled in ST_IDLE alone.
//  A note byte is accepted in ST_IDLE, then ST_SCAN compares up to VOICE_COUNT
//  voice slots (one table compare per cycle); it stops at the first match.
//  A velocity byte passes through ST_EMIT, which waits while the output word is stalled.
//  Synchronous active-low reset; the voice table is cleared at once.
//  Config writes are taken in every cycle.
// ----------------------------------------------------------------------------
`include "midi_note_voice_allocator_assert.svh"

module midi_note_voice_allocator #(
    parameter int VOICE_COUNT = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    // input bytes
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_midi_byte,
    // results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_event_kind,
    output logic [2:0]  o_voice_index,
    output logic [6:0]  o_voice_note,
    output logic [6:0]  o_voice_velocity,
    output logic [14:0] o_voice_amplitude,
    output logic [5:0]  o_trigger_mask
);

    localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_VOICE = IDX_W'(VOICE_COUNT - 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [1:0]             r_mode, n_mode;
    logic                   r_expect_vel, n_expect_vel;
    logic [IDX_W-1:0]       r_sel, n_sel;
    logic [IDX_W-1:0]       r_scan, n_scan;
    logic [7:0]             r_byte;
    logic [3:0]             r_listen;

    logic                   r_out_valid;
    logic                   r_out_kind;
    logic [2:0]             r_out_index;
    logic [6:0]             r_out_note;
    logic [6:0]             r_out_vel;
    logic [14:0]            r_out_amp;
    logic [5:0]             r_out_mask;

    mnva_pkg::t_tbl_cmd     w_cmd;
    logic [6:0]             w_rd_note;
    logic [VOICE_COUNT-1:0] w_trig;
    logic [VOICE_COUNT-1:0] w_trig_next;
    logic [5:0]             w_mask_next;

    logic                   w_in_acc;
    logic                   w_out_free;
    logic                   w_emit;
    logic                   w_match;
    logic                   w_ours;
    logic                   w_note_cmd;
    logic [3:0]             w_cmd_nib;
    logic                   w_vel_nz;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_emit      = (r_state == ST_EMIT) && w_out_free;
    assign w_vel_nz    = (r_byte[6:0] != 7'd0);

    // status decode
    assign w_cmd_nib  = i_midi_byte[7:4];
    assign w_ours     = (i_midi_byte[3:0] == r_listen);
    assign w_note_cmd = (w_cmd_nib == mnva_pkg::CMD_NOTE_ON) ||
                        (w_cmd_nib == mnva_pkg::CMD_NOTE_OFF);

    // scan compare: the one shared comparator against the addressed voice
    assign w_match = (w_rd_note == r_byte[6:0]) ||
                     ((r_mode == mnva_pkg::MODE_ON) && (w_rd_note == 7'd0));

    // listen channel register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listen <= mnva_pkg::LISTEN_CHANNEL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_listen <= i_cfg_data;
        end
    end

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_expect_vel = r_expect_vel;
        n_sel        = r_sel;
        n_scan       = r_scan;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_midi_byte[7]) begin
                        if (w_ours) begin
                            if (r_mode != mnva_pkg::MODE_ON &&
                                w_cmd_nib == mnva_pkg::CMD_NOTE_ON) begin
                                n_mode       = mnva_pkg::MODE_ON;
                                n_expect_vel = 1'b0;
                            end else if (r_mode != mnva_pkg::MODE_OFF &&
                                         w_cmd_nib == mnva_pkg::CMD_NOTE_OFF) begin
                                n_mode       = mnva_pkg::MODE_OFF;
                                n_expect_vel = 1'b0;
                            end
                        end else if (r_mode != mnva_pkg::MODE_IDLE && w_note_cmd) begin
                            n_mode       = mnva_pkg::MODE_IDLE;
                            n_expect_vel = 1'b0;
                        end
                    end else if (r_mode != mnva_pkg::MODE_IDLE) begin
                        if (r_expect_vel) begin
                            n_expect_vel = 1'b0;
                            n_state      = ST_EMIT;
                        end else begin
                            n_scan  = '0;
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (w_match || r_scan == LAST_VOICE) begin
                    if (w_match) begin
                        n_sel = r_scan;
                    end
                    n_expect_vel = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mode       <= mnva_pkg::MODE_IDLE;
            r_expect_vel <= 1'b0;
            r_sel        <= '0;
            r_scan       <= '0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_expect_vel <= n_expect_vel;
            r_sel        <= n_sel;
            r_scan       <= n_scan;
        end
    end

    // accepted data byte
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_byte <= i_midi_byte;
        end
    end

    // voice table access: scan index while scanning, else selected voice
    always_comb begin
        w_cmd            = '0;
        w_cmd.idx        = (r_state == ST_SCAN) ? 4'(r_scan) : 4'(r_sel);
        w_cmd.note_wdata = (r_mode == mnva_pkg::MODE_ON) ? r_byte[6:0] : 7'd0;
        if (r_state == ST_SCAN && w_match) begin
            w_cmd.note_we = 1'b1;
        end
        if (w_emit) begin
            w_cmd.trig_we    = 1'b1;
            w_cmd.trig_wdata = (r_mode == mnva_pkg::MODE_ON) && w_vel_nz;
            // note-on with zero velocity frees the voice
            if (r_mode == mnva_pkg::MODE_ON && !w_vel_nz) begin
                w_cmd.note_we    = 1'b1;
                w_cmd.note_wdata = 7'd0;
            end
        end
    end

    mnva_voice_table #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_voice_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_rd_note (w_rd_note),
        .o_trig    (w_trig)
    );

    // trigger bits after this message's update
    always_comb begin
        w_trig_next        = w_trig;
        w_trig_next[r_sel] = w_cmd.trig_wdata;
    end

    // only the low six voices show in the mask
    for (genvar g = 0; g < 6; g++) begin : g_mask
        if (g < VOICE_COUNT) begin : g_on
            assign w_mask_next[g] = w_trig_next[g];
        end else begin : g_off
            assign w_mask_next[g] = 1'b0;
        end
    end

    // output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output word payload; amplitude is velocity * 258 = v*256 + v*2
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_mask <= w_mask_next;
            if (r_mode == mnva_pkg::MODE_ON) begin
                r_out_kind  <= 1'b0;
                r_out_index <= 3'(r_sel);
                r_out_note  <= w_vel_nz ? w_rd_note : 7'd0;
                r_out_vel   <= r_byte[6:0];
                r_out_amp   <= {r_byte[6:0], 8'd0} + {7'd0, r_byte[6:0], 1'b0};
            end else begin
                r_out_kind  <= 1'b1;
                r_out_index <= 3'd0;
                r_out_note  <= 7'd0;
                r_out_vel   <= 7'd0;
                r_out_amp   <= 15'd0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_event_kind      = r_out_kind;
    assign o_voice_index     = r_out_index;
    assign o_voice_note      = r_out_note;
    assign o_voice_velocity  = r_out_vel;
    assign o_voice_amplitude = r_out_amp;
    assign o_trigger_mask    = r_out_mask;

    // checks
    `MNVA_ASSERT_IMPL(a_scan_in_range, i_clk, i_rst_n, (r_state == ST_SCAN),
        (r_scan <= LAST_VOICE), "voice scan index past last voice")
    `MNVA_ASSERT_NEXT(a_status_one_cycle, i_clk, i_rst_n, (w_in_acc && i_midi_byte[7]),
        (r_state == ST_IDLE), "status byte did not finish in one cycle")
    `MNVA_ASSERT_IMPL(a_rise_from_emit, i_clk, i_rst_n, $rose(r_out_valid),
        ($past(r_state) == ST_EMIT), "result appeared without a velocity byte")
    `MNVA_ASSERT_IMPL(a_off_fields_zero, i_clk, i_rst_n, (r_out_valid && r_out_kind),
        ((r_out_note == 7'd0) && (r_out_amp == 15'd0)), "note-off result carries voice data")
    `MNVA_ASSERT_IMPL(a_zero_vel_frees, i_clk, i_rst_n,
        (r_out_valid && !r_out_kind && (r_out_vel == 7'd0)),
        (r_out_note == 7'd0), "zero-velocity note-on left the voice held")

endmodule
